// ===== rtl/core/sst_pkg.sv =====
package sst_pkg;

	localparam int DEPTH       = 64;
	localparam int VALUE_WIDTH = 64;
	localparam int IDX_W       = $clog2(DEPTH);
	localparam int LEN_W       = $clog2(DEPTH + 1);
	localparam int PTR_W       = LEN_W + 1;

	localparam int OP_W    = 2;
	localparam int SLOT_W  = 6;
	localparam int COUNT_W = 7;

	typedef enum logic [OP_W-1:0] {
		OP_FIND     = 2'd0,
		OP_ADD      = 2'd1,
		OP_REMOVE   = 2'd2,
		OP_COMPRESS = 2'd3
	} op_t;

	typedef struct packed {
		logic load_in;
		logic scan_issue;
		logic rd_j;
		logic rd_i;
		logic drop;
		logic hold;
		logic i_dec;
		logic move;
		logic act;
		logic cfin;
	} cmd_t;

	typedef struct packed {
		logic match_now;
		logic pend;
		logic scan_more;
		logic rzero;
		logic j_neg;
		logic j_lt1;
		logic i_neg;
		logic out_free;
	} stat_t;

	typedef struct packed {
		logic               ovf;
		logic [COUNT_W-1:0] used;
		logic [COUNT_W-1:0] removed;
		logic [SLOT_W-1:0]  idx;
		logic               hit;
	} result_t;

	localparam int RES_W      = $bits(result_t);
	localparam int M_TDATA_W  = ((RES_W + 7) / 8) * 8;
	localparam int S_TDATA_W  = ((VALUE_WIDTH + 7) / 8) * 8;

endpackage

// ===== rtl/core/sst_ctrl.sv =====
module sst_ctrl import sst_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	input  op_t   in_op,
	output logic  in_ready,
	input  stat_t stat,
	output cmd_t  cmd
);

	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_SCAN   = 8'b0000_0010,
		S_ACT    = 8'b0000_0100,
		S_CJ_RD  = 8'b0000_1000,
		S_CJ_CHK = 8'b0001_0000,
		S_CI_RD  = 8'b0010_0000,
		S_CI_CHK = 8'b0100_0000,
		S_CDONE  = 8'b1000_0000
	} state_t;

	state_t state_q;
	state_t state_nxt;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		in_ready  = (state_q == S_IDLE);
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_nxt   = (in_op == OP_COMPRESS) ? S_CJ_RD : S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan_issue = stat.scan_more && !stat.match_now;
				if (stat.match_now || (!stat.pend && !stat.scan_more)) begin
					state_nxt = S_ACT;
				end
			end
			S_ACT: begin
				if (stat.out_free) begin
					cmd.act   = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			S_CJ_RD: begin
				if (stat.j_neg) begin
					state_nxt = S_CDONE;
				end else begin
					cmd.rd_j  = 1'b1;
					state_nxt = S_CJ_CHK;
				end
			end
			S_CJ_CHK: begin
				if (stat.rzero) begin
					cmd.drop  = 1'b1;
					state_nxt = S_CJ_RD;
				end else if (stat.j_lt1) begin
					state_nxt = S_CDONE;
				end else begin
					cmd.hold  = 1'b1;
					state_nxt = S_CI_RD;
				end
			end
			S_CI_RD: begin
				if (stat.i_neg) begin
					state_nxt = S_CDONE;
				end else begin
					cmd.rd_i  = 1'b1;
					state_nxt = S_CI_CHK;
				end
			end
			S_CI_CHK: begin
				if (stat.rzero) begin
					cmd.move  = 1'b1;
					state_nxt = S_CJ_RD;
				end else begin
					cmd.i_dec = 1'b1;
					state_nxt = S_CI_RD;
				end
			end
			S_CDONE: begin
				if (stat.out_free) begin
					cmd.cfin  = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

// ===== rtl/core/sst_dpath.sv =====
module sst_dpath import sst_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cmd_t                   cmd,
	input  op_t                    in_op,
	input  logic [VALUE_WIDTH-1:0] in_value,
	input  logic                   out_ready,
	output stat_t                  stat,
	output logic                   out_valid,
	output result_t                out_res
);

	logic [VALUE_WIDTH-1:0] mem [DEPTH];
	logic [VALUE_WIDTH-1:0] rdata_q;

	op_t                    op_q;
	logic [VALUE_WIDTH-1:0] value_q;
	logic [LEN_W-1:0]       len_q;
	logic [LEN_W-1:0]       a_q;
	logic                   pend_s1;
	logic [IDX_W-1:0]       idx_s1;
	logic                   found_q;
	logic [IDX_W-1:0]       fidx_q;
	logic signed [PTR_W-1:0] j_q;
	logic signed [PTR_W-1:0] i_q;
	logic [LEN_W-1:0]       nlen_q;
	logic [VALUE_WIDTH-1:0] move_q;
	logic                   out_valid_q;
	result_t                res_q;

	logic [VALUE_WIDTH-1:0] target;
	logic                   match_now;
	logic                   len_full;
	logic                   add_append;
	logic [LEN_W-1:0]       len_next;
	logic                   rd_en;
	logic [IDX_W-1:0]       rd_addr;
	logic                   wr_en;
	logic [IDX_W-1:0]       wr_addr;
	logic [VALUE_WIDTH-1:0] wr_data;
	result_t                res_act;
	result_t                res_cmp;

	assign target     = (op_q == OP_ADD) ? '0 : value_q;
	assign match_now  = pend_s1 && (rdata_q == target);
	assign len_full   = (len_q == LEN_W'(DEPTH));
	assign add_append = (op_q == OP_ADD) && !found_q && !len_full;
	assign len_next   = add_append ? len_q + LEN_W'(1) : len_q;

	assign stat.match_now = match_now;
	assign stat.pend      = pend_s1;
	assign stat.scan_more = (a_q < len_q);
	assign stat.rzero     = (rdata_q == '0);
	assign stat.j_neg     = j_q[PTR_W-1];
	assign stat.j_lt1     = j_q[PTR_W-1] || (j_q == '0);
	assign stat.i_neg     = i_q[PTR_W-1];
	assign stat.out_free  = !out_valid_q || out_ready;

	assign rd_en   = cmd.scan_issue || cmd.rd_j || cmd.rd_i;
	assign rd_addr = cmd.scan_issue ? a_q[IDX_W-1:0] :
	                 cmd.rd_j       ? j_q[IDX_W-1:0] : i_q[IDX_W-1:0];

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = '0;
		if (cmd.act) begin
			unique case (op_q)
				OP_ADD: begin
					if (found_q) begin
						wr_en   = 1'b1;
						wr_addr = fidx_q;
						wr_data = value_q;
					end else if (!len_full) begin
						wr_en   = 1'b1;
						wr_addr = len_q[IDX_W-1:0];
						wr_data = value_q;
					end
				end
				OP_REMOVE: begin
					if (found_q) begin
						wr_en   = 1'b1;
						wr_addr = fidx_q;
					end
				end
				OP_FIND, OP_COMPRESS: begin
				end
			endcase
		end else if (cmd.move) begin
			wr_en   = 1'b1;
			wr_addr = i_q[IDX_W-1:0];
			wr_data = move_q;
		end
	end

	always_comb begin
		res_act         = '0;
		res_act.used    = COUNT_W'(len_next);
		res_act.hit     = found_q && ((op_q == OP_FIND) || (op_q == OP_REMOVE));
		res_act.ovf     = (op_q == OP_ADD) && !found_q && len_full;
		if (((op_q == OP_FIND) || (op_q == OP_ADD)) && found_q) begin
			res_act.idx = SLOT_W'(fidx_q);
		end else if (add_append) begin
			res_act.idx = SLOT_W'(len_q);
		end
		res_cmp         = '0;
		res_cmp.used    = COUNT_W'(nlen_q);
		res_cmp.removed = COUNT_W'(len_q - nlen_q);
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q    <= in_op;
			value_q <= in_value;
			a_q     <= '0;
			found_q <= 1'b0;
			j_q     <= signed'({1'b0, len_q}) - PTR_W'(1);
			i_q     <= signed'({1'b0, len_q}) - PTR_W'(2);
			nlen_q  <= len_q;
		end
		if (cmd.scan_issue) begin
			a_q    <= a_q + LEN_W'(1);
			idx_s1 <= a_q[IDX_W-1:0];
		end
		if (match_now) begin
			found_q <= 1'b1;
			fidx_q  <= idx_s1;
		end
		if (cmd.drop || cmd.move) begin
			nlen_q <= nlen_q - LEN_W'(1);
			j_q    <= j_q - PTR_W'(1);
		end
		if (cmd.hold) begin
			move_q <= rdata_q;
			if (i_q > j_q) begin
				i_q <= j_q - PTR_W'(1);
			end
		end
		if (cmd.i_dec) begin
			i_q <= i_q - PTR_W'(1);
		end
		if (cmd.act) begin
			res_q <= res_act;
		end else if (cmd.cfin) begin
			res_q <= res_cmp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= '0;
			pend_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			pend_s1 <= cmd.scan_issue;
			if (cmd.act) begin
				len_q <= len_next;
			end else if (cmd.cfin) begin
				len_q <= nlen_q;
			end
			if (cmd.act || cmd.cfin) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = res_q;

`ifndef ASSERT_OFF
	a_move_down: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.move |-> (i_q < j_q))
		else $error("Compaction moved an entry upward.");

	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |-> ({1'b0, idx_s1} < len_q))
		else $error("Scan read a slot at or beyond the length.");

	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.act || cmd.cfin) |-> stat.out_free)
		else $error("Result loaded while the output register was occupied.");

	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.ovf) |-> (res_q.used == COUNT_W'(DEPTH)))
		else $error("Overflow reported while the table was not full.");

	a_hold_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.hold |-> !stat.rzero)
		else $error("Compaction picked an empty slot to move.");
`endif

endmodule

// ===== rtl/core/sparse_slot_table.sv =====
// Find, add and remove scan the used slots in order through one memory read port,
// so a transaction ends at the first match or when the used slots run out. Compress
// visits each slot through the same port. One transaction is processed at a time.
// Reset clears the length, the controller and the output valid; the slot memory is
// not cleared, and slots are written before the length grows past them.
module sparse_slot_table import sst_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// Fields from bit 0: value.
	input  logic [S_TDATA_W-1:0] s_tdata,
	// Fields from bit 0: op.
	input  logic [OP_W-1:0]      s_tuser,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// Fields from bit 0: hit, slot_index, removed_count, used_length, overflow.
	output logic [M_TDATA_W-1:0] m_tdata
);

	cmd_t    cmd;
	stat_t   stat;
	result_t res;

	sst_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_op    (op_t'(s_tuser)),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	sst_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_op     (op_t'(s_tuser)),
		.in_value  (s_tdata[VALUE_WIDTH-1:0]),
		.out_ready (m_tready),
		.stat      (stat),
		.out_valid (m_tvalid),
		.out_res   (res)
	);

	assign m_tdata = M_TDATA_W'(res);

endmodule
